FILE: sv/aims_pkg.sv
// shared types and constants for the affine inverse map sampler
package aims_pkg;

    // field and datapath widths
    localparam int DIN_W     = 12;
    localparam int COEF_W    = 32;
    localparam int DIM_W     = 13;
    localparam int CRD_W     = 12;
    localparam int IDX_W     = 24;
    localparam int PROD_W    = DIN_W + COEF_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int CFG_IDX_W = 3;

    // register reset values
    localparam logic signed [COEF_W-1:0] COEF_RST_ONE  = 32'sd65536;
    localparam logic signed [COEF_W-1:0] COEF_RST_ZERO = 32'sd0;
    localparam logic [DIM_W-1:0]         DIM_RST       = 13'd4096;

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_XX = 3'd0,
        CFG_COEF_XY = 3'd1,
        CFG_OFF_X   = 3'd2,
        CFG_COEF_YX = 3'd3,
        CFG_COEF_YY = 3'd4,
        CFG_OFF_Y   = 3'd5,
        CFG_IMG_W   = 3'd6,
        CFG_IMG_H   = 3'd7
    } t_cfg_idx;

    // affine matrix and translation, all q16.16 two's complement
    typedef struct packed {
        logic signed [COEF_W-1:0] coef_xx;
        logic signed [COEF_W-1:0] coef_xy;
        logic signed [COEF_W-1:0] off_x;
        logic signed [COEF_W-1:0] coef_yx;
        logic signed [COEF_W-1:0] coef_yy;
        logic signed [COEF_W-1:0] off_y;
    } t_affine_cfg;

    // rounded source point after the bounds test
    typedef struct packed {
        logic             in_range;
        logic [DIM_W-1:0] cx;
        logic [DIM_W-1:0] cy;
    } t_coord;

endpackage

FILE: sv/affine_inverse_map_sampler_core.sv
// Affine inverse-map sampler: one destination pixel per clock in, one source
// point per clock out while i_m_tready stays high, through the four register
// stages (coefficient multipliers, four-term adder, bounds test, index
// multiply-add). Valid bits travel with each stage and a stage loads whenever
// it is empty or the one after it moves, so o_s_tready follows i_m_tready and
// the stage occupancy combinationally. Configuration writes take effect at
// once and must only be made while the pipeline is empty.
module affine_inverse_map_sampler_core
    import aims_pkg::*;
#(
    parameter int MAX_DIM   = 4096,
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave side, tdata: dst_x [11:0], dst_y [23:12]
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [23:0]          i_s_tdata,
    // master side, tdata: src_x [11:0], src_y [23:12], src_index [47:24]
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [47:0]          o_m_tdata,
    // tuser: in_range [0]
    output logic                 o_m_tuser,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_wdata
);

    localparam int NSTG = 4;

    t_affine_cfg               r_cfg;
    logic [DIM_W-1:0]          r_img_w, r_img_h;
    logic [DIM_W-1:0]          w_width, w_height;
    logic [NSTG-1:0]           r_valid;
    logic [NSTG-1:0]           w_ld;
    logic signed [SUM_W-1:0]   w_sx, w_sy;
    t_coord                    w_coord;
    logic                      w_in_range;
    logic [CRD_W-1:0]          w_src_x, w_src_y;
    logic [IDX_W-1:0]          w_src_index;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_xx <= COEF_RST_ONE;
            r_cfg.coef_xy <= COEF_RST_ZERO;
            r_cfg.off_x   <= COEF_RST_ZERO;
            r_cfg.coef_yx <= COEF_RST_ZERO;
            r_cfg.coef_yy <= COEF_RST_ONE;
            r_cfg.off_y   <= COEF_RST_ZERO;
            r_img_w       <= DIM_RST;
            r_img_h       <= DIM_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_COEF_XX: r_cfg.coef_xx <= i_cfg_wdata;
                CFG_COEF_XY: r_cfg.coef_xy <= i_cfg_wdata;
                CFG_OFF_X:   r_cfg.off_x   <= i_cfg_wdata;
                CFG_COEF_YX: r_cfg.coef_yx <= i_cfg_wdata;
                CFG_COEF_YY: r_cfg.coef_yy <= i_cfg_wdata;
                CFG_OFF_Y:   r_cfg.off_y   <= i_cfg_wdata;
                CFG_IMG_W:   r_img_w       <= i_cfg_wdata[DIM_W-1:0];
                CFG_IMG_H:   r_img_h       <= i_cfg_wdata[DIM_W-1:0];
            endcase
        end
    end

    // oversized dimensions clip to the maximum
    always_comb begin
        w_width  = (32'(r_img_w) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_img_w;
        w_height = (32'(r_img_h) > 32'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_img_h;
    end

    // stage load enables: a stage moves when empty or when its successor moves
    always_comb begin
        w_ld[NSTG-1] = !r_valid[NSTG-1] || i_m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_ld[k] = !r_valid[k] || w_ld[k+1];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_ld[0]) begin
                r_valid[0] <= i_s_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_ld[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    aims_xform #(
        .FRAC_BITS (FRAC_BITS)
    ) u_xform (
        .i_clk   (i_clk),
        .i_ld    (w_ld[1:0]),
        .i_dst_x (i_s_tdata[DIN_W-1:0]),
        .i_dst_y (i_s_tdata[2*DIN_W-1:DIN_W]),
        .i_cfg   (r_cfg),
        .o_sx    (w_sx),
        .o_sy    (w_sy)
    );

    aims_bound #(
        .FRAC_BITS (FRAC_BITS)
    ) u_bound (
        .i_clk    (i_clk),
        .i_ld     (w_ld[2]),
        .i_sx     (w_sx),
        .i_sy     (w_sy),
        .i_width  (w_width),
        .i_height (w_height),
        .o_coord  (w_coord)
    );

    aims_index u_index (
        .i_clk       (i_clk),
        .i_ld        (w_ld[3]),
        .i_coord     (w_coord),
        .i_width     (w_width),
        .o_in_range  (w_in_range),
        .o_src_x     (w_src_x),
        .o_src_y     (w_src_y),
        .o_src_index (w_src_index)
    );

    // stream outputs
    assign o_s_tready = w_ld[0];
    assign o_m_tvalid = r_valid[NSTG-1];
    assign o_m_tdata  = {w_src_index, w_src_y, w_src_x};
    assign o_m_tuser  = w_in_range;

endmodule

FILE: sv/aims_xform.sv
// matrix multiply and sum stages: products, then q-format source coordinates plus one half
module aims_xform
    import aims_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic [1:0]               i_ld,
    input  logic signed [DIN_W-1:0]  i_dst_x,
    input  logic signed [DIN_W-1:0]  i_dst_y,
    input  t_affine_cfg              i_cfg,
    output logic signed [SUM_W-1:0]  o_sx,
    output logic signed [SUM_W-1:0]  o_sy
);

    localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (FRAC_BITS - 1);

    logic signed [PROD_W-1:0] r_pxx, r_pxy, r_pyx, r_pyy;
    logic signed [PROD_W-1:0] n_pxx, n_pxy, n_pyx, n_pyy;
    logic signed [SUM_W-1:0]  r_sx, r_sy;
    logic signed [SUM_W-1:0]  n_sx, n_sy;

    // four 12x32 products, exact in 44 bits
    always_comb begin
        n_pxx = PROD_W'(i_dst_x) * PROD_W'(i_cfg.coef_xx);
        n_pxy = PROD_W'(i_dst_y) * PROD_W'(i_cfg.coef_xy);
        n_pyx = PROD_W'(i_dst_x) * PROD_W'(i_cfg.coef_yx);
        n_pyy = PROD_W'(i_dst_y) * PROD_W'(i_cfg.coef_yy);
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r_pxx <= n_pxx;
            r_pxy <= n_pxy;
            r_pyx <= n_pyx;
            r_pyy <= n_pyy;
        end
    end

    // sum with translation and rounding half
    always_comb begin
        n_sx = SUM_W'(r_pxx) + SUM_W'(r_pxy) + SUM_W'(i_cfg.off_x) + HALF;
        n_sy = SUM_W'(r_pyx) + SUM_W'(r_pyy) + SUM_W'(i_cfg.off_y) + HALF;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld[1]) begin
            r_sx <= n_sx;
            r_sy <= n_sy;
        end
    end

    assign o_sx = r_sx;
    assign o_sy = r_sy;

endmodule

FILE: sv/aims_bound.sv
// bounds test stage: floor to integer pixel and compare against the image size
module aims_bound
    import aims_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_ld,
    input  logic signed [SUM_W-1:0] i_sx,
    input  logic signed [SUM_W-1:0] i_sy,
    input  logic [DIM_W-1:0]        i_width,
    input  logic [DIM_W-1:0]        i_height,
    output t_coord                  o_coord
);

    localparam int HI_W = SUM_W - FRAC_BITS;

    logic [HI_W-1:0] w_hx, w_hy;
    logic            w_okx, w_oky;
    t_coord          n_coord;
    t_coord          r_coord;

    // integer part is the floor; in range when non-negative and below the dimension
    always_comb begin
        w_hx  = i_sx[SUM_W-1:FRAC_BITS];
        w_hy  = i_sy[SUM_W-1:FRAC_BITS];
        w_okx = !w_hx[HI_W-1] && (w_hx < HI_W'(i_width));
        w_oky = !w_hy[HI_W-1] && (w_hy < HI_W'(i_height));
        n_coord.in_range = w_okx && w_oky;
        n_coord.cx = n_coord.in_range ? w_hx[DIM_W-1:0] : '0;
        n_coord.cy = n_coord.in_range ? w_hy[DIM_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_coord <= n_coord;
        end
    end

    assign o_coord = r_coord;

endmodule

FILE: sv/aims_index.sv
// output stage: linear index row times width plus column
module aims_index
    import aims_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_ld,
    input  t_coord           i_coord,
    input  logic [DIM_W-1:0] i_width,
    output logic             o_in_range,
    output logic [CRD_W-1:0] o_src_x,
    output logic [CRD_W-1:0] o_src_y,
    output logic [IDX_W-1:0] o_src_index
);

    localparam int MAC_W = 2 * DIM_W + 1;

    logic [MAC_W-1:0] n_mac;
    logic             r_in_range;
    logic [CRD_W-1:0] r_src_x, r_src_y;
    logic [IDX_W-1:0] r_src_index;

    // 13x13 multiply and add; out-of-range points arrive as zero
    assign n_mac = MAC_W'(i_coord.cy) * MAC_W'(i_width) + MAC_W'(i_coord.cx);

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_in_range  <= i_coord.in_range;
            r_src_x     <= i_coord.cx[CRD_W-1:0];
            r_src_y     <= i_coord.cy[CRD_W-1:0];
            r_src_index <= n_mac[IDX_W-1:0];
        end
    end

    assign o_in_range  = r_in_range;
    assign o_src_x     = r_src_x;
    assign o_src_y     = r_src_y;
    assign o_src_index = r_src_index;

endmodule

FILE: sv/aims_checker.sv
// port-level checks for the sampler core and their binding
module aims_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [47:0] o_m_tdata,
    input logic        o_m_tuser
);

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("stalled result changed");

    // out-of-range transactions carry all-zero coordinates and index
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata == 48'd0)
        else $error("out-of-range result not zero");

    // on row zero the index equals the column
    a_row0_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser && o_m_tdata[23:12] == 12'd0
        |-> o_m_tdata[47:24] == {12'd0, o_m_tdata[11:0]})
        else $error("row zero index mismatch");

    // an empty output stage never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

endmodule

bind affine_inverse_map_sampler_core aims_checker u_aims_checker (.*);
